### src/clw_pkg.sv
// ----------------------------------------------------------------------------
// clw_pkg: shared types and constants for the collation weight comparator
// Holds the weight and order types, the order codes, the queue side codes
// and the weight compare function.
// ----------------------------------------------------------------------------
package clw_pkg;

    // Number of collation levels (primary to quaternary).
    localparam int LEVELS   = 4;
    localparam int WEIGHT_W = 16;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic signed [1:0]   order_t;

    // Order codes: left sorts first, equal or undecided, right sorts first.
    localparam order_t ORDER_LEFT  = 2'sb11;
    localparam order_t ORDER_EQUAL = 2'sb00;
    localparam order_t ORDER_RIGHT = 2'sb01;

    // Which side owns the pending weights of a level queue.
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // One result request as held in the output buffer.
    typedef struct packed {
        order_t order;
        logic   decided;
        logic   overflow;
    } res_t;

    // Three-way compare of two weights.
    function automatic order_t cmp_weight(weight_t a, weight_t b);
        order_t r;
        if (a < b)
        begin
            r = ORDER_LEFT;
        end
        else if (a > b)
        begin
            r = ORDER_RIGHT;
        end
        else
        begin
            r = ORDER_EQUAL;
        end
        return r;
    endfunction

endpackage

### src/clw_ifs.sv
// ----------------------------------------------------------------------------
// clw_ifs: request and result channels of the collation weight comparator
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface clw_req_if;
    import clw_pkg::*;

    logic    valid;
    logic    ready;
    weight_t left_primary_weight;
    weight_t left_secondary_weight;
    weight_t left_tertiary_weight;
    weight_t left_quaternary_weight;
    weight_t right_primary_weight;
    weight_t right_secondary_weight;
    weight_t right_tertiary_weight;
    weight_t right_quaternary_weight;
    logic    last_element;

    modport source (
        output valid,
        output left_primary_weight,
        output left_secondary_weight,
        output left_tertiary_weight,
        output left_quaternary_weight,
        output right_primary_weight,
        output right_secondary_weight,
        output right_tertiary_weight,
        output right_quaternary_weight,
        output last_element,
        input  ready
    );

    modport sink (
        input  valid,
        input  left_primary_weight,
        input  left_secondary_weight,
        input  left_tertiary_weight,
        input  left_quaternary_weight,
        input  right_primary_weight,
        input  right_secondary_weight,
        input  right_tertiary_weight,
        input  right_quaternary_weight,
        input  last_element,
        output ready
    );
endinterface

interface clw_res_if;
    import clw_pkg::*;

    logic   valid;
    logic   ready;
    order_t order;
    logic   decided;
    logic   overflow;

    modport source (
        output valid,
        output order,
        output decided,
        output overflow,
        input  ready
    );

    modport sink (
        input  valid,
        input  order,
        input  decided,
        input  overflow,
        output ready
    );
endinterface

### src/collation_weight_compare_unit.sv
// ----------------------------------------------------------------------------
// collation_weight_compare_unit: multilevel collation weight comparator
// The block takes one pair of collation elements per request and returns one
// result per request. Every request is worked in one pass of logic: the four
// level queues are updated and the head pairs compared together, and the
// result lands in a two-entry output buffer. A request can therefore be taken
// in every cycle while the buffer has room, and its result is registered. The
// output buffer lets one further request in while a result waits; ready
// falls only when both entries are full. Each level holds QUEUE_DEPTH
// weights, and at most one side of a level ever has weights waiting, so a
// single queue per level is kept together with the side that owns it.
// ----------------------------------------------------------------------------
module collation_weight_compare_unit #(
    parameter int QUEUE_DEPTH = 8
) (
    input logic       clk,
    input logic       rst_n,
    clw_req_if.sink   req,
    clw_res_if.source res
);
    import clw_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;

    // Level state.
    weight_t          queue_reg   [LEVELS][QUEUE_DEPTH];
    weight_t          queue_next  [LEVELS][QUEUE_DEPTH];
    weight_t          queue_tmp   [LEVELS][QUEUE_DEPTH];
    logic [CNT_W-1:0] cnt_reg     [LEVELS];
    logic [CNT_W-1:0] cnt_next    [LEVELS];
    logic             side_reg    [LEVELS];
    logic             side_next   [LEVELS];
    order_t           verdict_reg [LEVELS];
    order_t           verdict_next[LEVELS];
    logic             overflow_seen_reg;

    // Per level working values.
    weight_t          lw        [LEVELS];
    weight_t          rw        [LEVELS];
    weight_t          own_w     [LEVELS];
    weight_t          other_w   [LEVELS];
    order_t           head_cmp  [LEVELS];
    order_t           final_ord [LEVELS];
    logic             add_w     [LEVELS];
    logic             pop_w     [LEVELS];
    logic [LEVELS-1:0] drop_w;

    // Output buffer.
    logic res_valid_reg;
    res_t res_reg;
    logic skid_valid_reg;
    res_t skid_reg;

    logic accept;
    logic res_take;
    logic primary_done;
    res_t res_new;

    assign req.ready = !skid_valid_reg;
    assign accept    = req.valid && req.ready;
    assign res_take  = res_valid_reg && res.ready;

    assign res.valid    = res_valid_reg;
    assign res.order    = res_reg.order;
    assign res.decided  = res_reg.decided;
    assign res.overflow = res_reg.overflow;

    // Gather the weights by level.
    always_comb
    begin
        lw[0] = req.left_primary_weight;
        lw[1] = req.left_secondary_weight;
        lw[2] = req.left_tertiary_weight;
        lw[3] = req.left_quaternary_weight;
        rw[0] = req.right_primary_weight;
        rw[1] = req.right_secondary_weight;
        rw[2] = req.right_tertiary_weight;
        rw[3] = req.right_quaternary_weight;
    end

    // Queue update and head compare, one independent pass per level.
    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            queue_tmp[l]    = queue_reg[l];
            queue_next[l]   = queue_reg[l];
            cnt_next[l]     = cnt_reg[l];
            side_next[l]    = side_reg[l];
            verdict_next[l] = verdict_reg[l];
            own_w[l]        = (side_reg[l] == SIDE_LEFT) ? lw[l] : rw[l];
            other_w[l]      = (side_reg[l] == SIDE_LEFT) ? rw[l] : lw[l];
            head_cmp[l]     = (side_reg[l] == SIDE_LEFT)
                              ? cmp_weight(queue_reg[l][0], other_w[l])
                              : cmp_weight(other_w[l], queue_reg[l][0]);
            add_w[l]        = 1'b0;
            pop_w[l]        = 1'b0;
            drop_w[l]       = 1'b0;

            if (verdict_reg[l] == ORDER_EQUAL)
            begin
                if (cnt_reg[l] == CNT_ZERO)
                begin
                    // Empty level: a full pair compares at once, a lone
                    // weight starts the queue for its side.
                    if (lw[l] != '0 && rw[l] != '0)
                    begin
                        verdict_next[l] = cmp_weight(lw[l], rw[l]);
                    end
                    else if (lw[l] != '0)
                    begin
                        queue_next[l][0] = lw[l];
                        cnt_next[l]      = CNT_W'(1);
                        side_next[l]     = SIDE_LEFT;
                    end
                    else if (rw[l] != '0)
                    begin
                        queue_next[l][0] = rw[l];
                        cnt_next[l]      = CNT_W'(1);
                        side_next[l]     = SIDE_RIGHT;
                    end
                end
                else
                begin
                    // Owning side appends; the other side meets the head.
                    add_w[l]  = (own_w[l] != '0) && (cnt_reg[l] != CNT_FULL);
                    drop_w[l] = (own_w[l] != '0) && (cnt_reg[l] == CNT_FULL);
                    pop_w[l]  = (other_w[l] != '0) && (head_cmp[l] == ORDER_EQUAL);
                    if (other_w[l] != '0 && head_cmp[l] != ORDER_EQUAL)
                    begin
                        verdict_next[l] = head_cmp[l];
                    end
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (add_w[l] && cnt_reg[l] == CNT_W'(i))
                        begin
                            queue_tmp[l][i] = own_w[l];
                        end
                    end
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (pop_w[l] && i < QUEUE_DEPTH - 1)
                        begin
                            queue_next[l][i] = queue_tmp[l][(i + 1) % QUEUE_DEPTH];
                        end
                        else
                        begin
                            queue_next[l][i] = queue_tmp[l][i];
                        end
                    end
                    cnt_next[l] = cnt_reg[l] + {{(CNT_W-1){1'b0}}, add_w[l]}
                                  - {{(CNT_W-1){1'b0}}, pop_w[l]};
                end
            end

            // End-of-string answer for this level: a side still holding
            // weights sorts after the side that has run out.
            if (verdict_next[l] != ORDER_EQUAL)
            begin
                final_ord[l] = verdict_next[l];
            end
            else if (cnt_next[l] != CNT_ZERO)
            begin
                final_ord[l] = (side_next[l] == SIDE_LEFT) ? ORDER_RIGHT : ORDER_LEFT;
            end
            else
            begin
                final_ord[l] = ORDER_EQUAL;
            end
        end
    end

    // Result of the request: a primary verdict ends at once, the last
    // element settles the levels in order.
    always_comb
    begin
        primary_done     = (verdict_next[0] != ORDER_EQUAL);
        res_new.decided  = primary_done || req.last_element;
        res_new.overflow = overflow_seen_reg || drop_w[0]
                           || (!primary_done && (|drop_w[LEVELS-1:1]));
        res_new.order    = ORDER_EQUAL;
        if (primary_done)
        begin
            res_new.order = verdict_next[0];
        end
        else if (req.last_element)
        begin
            for (int l = LEVELS - 1; l >= 0; l--)
            begin
                if (final_ord[l] != ORDER_EQUAL)
                begin
                    res_new.order = final_ord[l];
                end
            end
        end
    end

    // Level control state; cleared after every decided result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                cnt_reg[l]     <= CNT_ZERO;
                side_reg[l]    <= SIDE_LEFT;
                verdict_reg[l] <= ORDER_EQUAL;
            end
            overflow_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            for (int l = 0; l < LEVELS; l++)
            begin
                cnt_reg[l]     <= res_new.decided ? CNT_ZERO : cnt_next[l];
                side_reg[l]    <= res_new.decided ? SIDE_LEFT : side_next[l];
                verdict_reg[l] <= res_new.decided ? ORDER_EQUAL : verdict_next[l];
            end
            overflow_seen_reg <= res_new.decided ? 1'b0 : res_new.overflow;
        end
    end

    // Queue contents; only the entries below the count are ever read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg <= queue_next;
        end
    end

    // Two-entry output buffer: main register plus skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_take)
            begin
                if (skid_valid_reg)
                begin
                    res_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    res_valid_reg <= accept;
                end
            end
            else if (!res_valid_reg)
            begin
                res_valid_reg <= accept;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            if (skid_valid_reg)
            begin
                res_reg <= skid_reg;
            end
            else if (accept)
            begin
                res_reg <= res_new;
            end
        end
        else if (!res_valid_reg)
        begin
            if (accept)
            begin
                res_reg <= res_new;
            end
        end
        else if (accept)
        begin
            skid_reg <= res_new;
        end
    end

`ifndef ASSERT_OFF
    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry valid without a main result");

    // A decided result starts a fresh comparison.
    a_clear_after_decided: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_new.decided) |=>
            (!overflow_seen_reg && cnt_reg[0] == CNT_ZERO
             && verdict_reg[1] == ORDER_EQUAL))
        else $error("state not cleared after a decided result");

    // The primary level never holds a verdict across requests.
    a_primary_never_held: assert property (@(posedge clk) disable iff (!rst_n)
        verdict_reg[0] == ORDER_EQUAL)
        else $error("primary verdict held past its request");

    // A dropped weight in an open comparison is remembered.
    a_overflow_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && drop_w[0] && !res_new.decided) |=> overflow_seen_reg)
        else $error("queue overflow not recorded");

    // A full buffer stops new requests.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && skid_valid_reg) |-> !accept)
        else $error("request accepted with a full output buffer");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for collation_weight_compare_unit
// Feeds element pairs as whole and broken comparisons, noise and queue
// overflow runs, predicts every result from a behavioural copy of the level
// queues, and checks each result field by field under random idling.
// ----------------------------------------------------------------------------
module tb_top;
    import clw_pkg::*;

    localparam int QUEUE_DEPTH  = 8;
    localparam int MAX_GAP      = 12;
    localparam int TOTAL_ITEMS  = 1900;
    localparam int LONG_HOLD    = 200;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 500000;

    // One request: a collation element from each side plus the last flag.
    typedef struct packed {
        logic [LEVELS-1:0][WEIGHT_W-1:0] lw;
        logic [LEVELS-1:0][WEIGHT_W-1:0] rw;
        logic                            last;
    } elem_pair_t;

    // Behavioural copy of the comparator with the list of orders still owed.
    class collation_order_board #(int DEPTH = 8);

        weight_t left_q  [LEVELS][DEPTH];
        weight_t right_q [LEVELS][DEPTH];
        int      head    [LEVELS];
        int      lcnt    [LEVELS];
        int      rcnt    [LEVELS];
        order_t  verdict [LEVELS];
        bit      ovf_seen;
        res_t    expected_orders[$];
        int      errors;

        function new();
            errors = 0;
            clear_levels();
        endfunction

        function void clear_levels();
            for (int lvl = 0; lvl < LEVELS; lvl++)
            begin
                for (int s = 0; s < DEPTH; s++)
                begin
                    left_q[lvl][s]  = '0;
                    right_q[lvl][s] = '0;
                end
                head[lvl]    = 0;
                lcnt[lvl]    = 0;
                rcnt[lvl]    = 0;
                verdict[lvl] = ORDER_EQUAL;
            end
            ovf_seen = 1'b0;
        endfunction

        function order_t weigh(weight_t a, weight_t b);
            if (a < b)
            begin
                return ORDER_LEFT;
            end
            if (a > b)
            begin
                return ORDER_RIGHT;
            end
            return ORDER_EQUAL;
        endfunction

        // Queue the nonzero weights of one level and compare its head pair.
        function void push_level_weights(int lvl, weight_t lw, weight_t rw);
            int     h;
            order_t c;
            if (verdict[lvl] != ORDER_EQUAL)
            begin
                return;
            end
            if (lw != '0)
            begin
                if (lcnt[lvl] >= DEPTH)
                begin
                    ovf_seen = 1'b1;
                end
                else
                begin
                    left_q[lvl][(head[lvl] + lcnt[lvl]) % DEPTH] = lw;
                    lcnt[lvl]++;
                end
            end
            if (rw != '0)
            begin
                if (rcnt[lvl] >= DEPTH)
                begin
                    ovf_seen = 1'b1;
                end
                else
                begin
                    right_q[lvl][(head[lvl] + rcnt[lvl]) % DEPTH] = rw;
                    rcnt[lvl]++;
                end
            end
            if (lcnt[lvl] > 0 && rcnt[lvl] > 0)
            begin
                h = head[lvl];
                c = weigh(left_q[lvl][h], right_q[lvl][h]);
                if (c != ORDER_EQUAL)
                begin
                    verdict[lvl] = c;
                end
                else
                begin
                    left_q[lvl][h]  = '0;
                    right_q[lvl][h] = '0;
                    head[lvl]       = (h + 1) % DEPTH;
                    lcnt[lvl]--;
                    rcnt[lvl]--;
                end
            end
        endfunction

        // Verdict of a level at the end: an empty side counts as weight zero.
        function order_t settle_level(int lvl);
            weight_t lw;
            weight_t rw;
            if (verdict[lvl] != ORDER_EQUAL)
            begin
                return verdict[lvl];
            end
            lw = (lcnt[lvl] > 0) ? left_q[lvl][head[lvl]] : '0;
            rw = (rcnt[lvl] > 0) ? right_q[lvl][head[lvl]] : '0;
            return weigh(lw, rw);
        endfunction

        // Works out the result of an accepted request.
        function void note_request(elem_pair_t p);
            res_t r;
            r.order   = ORDER_EQUAL;
            r.decided = 1'b0;
            for (int lvl = 0; lvl < LEVELS; lvl++)
            begin
                push_level_weights(lvl, p.lw[lvl], p.rw[lvl]);
                if (lvl == 0 && verdict[0] != ORDER_EQUAL)
                begin
                    r.order   = verdict[0];
                    r.decided = 1'b1;
                    break;
                end
            end
            if (!r.decided && p.last)
            begin
                r.decided = 1'b1;
                for (int lvl = 0; lvl < LEVELS; lvl++)
                begin
                    r.order = settle_level(lvl);
                    if (r.order != ORDER_EQUAL)
                    begin
                        break;
                    end
                end
            end
            r.overflow = ovf_seen;
            expected_orders.push_back(r);
            if (r.decided)
            begin
                clear_levels();
            end
        endfunction

        function void check_result(order_t o, logic d, logic v);
            res_t e;
            if (expected_orders.size() == 0)
            begin
                $error("result with none owed: order %0d decided %0b overflow %0b", o, d, v);
                errors++;
                return;
            end
            e = expected_orders.pop_front();
            if (o !== e.order)
            begin
                $error("order mismatch: expected %0d, got %0d", e.order, o);
                errors++;
            end
            if (d !== e.decided)
            begin
                $error("decided mismatch: expected %0b, got %0b", e.decided, d);
                errors++;
            end
            if (v !== e.overflow)
            begin
                $error("overflow mismatch: expected %0b, got %0b", e.overflow, v);
                errors++;
            end
        endfunction

        function int pending();
            return expected_orders.size();
        endfunction

    endclass

    typedef enum int {SEQ_EQUAL, SEQ_DIVERGE, SEQ_OVERFLOW, SEQ_NOISE} seq_kind_e;

    logic clk = 1'b0;
    logic rst_n;

    clw_req_if req_ch ();
    clw_res_if res_ch ();

    collation_order_board #(QUEUE_DEPTH) order_board;

    bit          sender_busy   = 1'b0;
    bit          receiver_busy = 1'b0;
    bit          hold_results  = 1'b0;
    int          requests_sent = 0;
    int unsigned cycle_count   = 0;

    collation_weight_compare_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("collation_weight_compare_unit test failed");
            $finish;
        end
    end

    // Every result taken by the bench is checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            order_board.check_result(res_ch.order, res_ch.decided, res_ch.overflow);
        end
    end

    // Result side: random stalls per result, with one long hold on request.
    initial
    begin : result_sink
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_results = 1'b0;
            end
            stall = receiver_busy ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
        end
    end

    function automatic elem_pair_t make_pair(weight_t lp, weight_t ls, weight_t lt,
                                             weight_t lq, weight_t rp, weight_t rs,
                                             weight_t rt, weight_t rq, logic last);
        elem_pair_t p;
        p.lw   = {lq, lt, ls, lp};
        p.rw   = {rq, rt, rs, rp};
        p.last = last;
        return p;
    endfunction

    // Nonzero weight: small values make ties likely, extremes hit the edges.
    function automatic weight_t pick_weight();
        case ($urandom_range(0, 3))
            0: return weight_t'($urandom_range(1, 4));
            1: return ($urandom_range(0, 1) != 0) ? weight_t'(1) : weight_t'(16'hFFFF);
            default: return weight_t'($urandom_range(1, 65535));
        endcase
    endfunction

    // Offers one request after a random gap and waits until it is taken.
    task automatic send_request(input elem_pair_t p);
        int gap;
        gap = sender_busy ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid                   <= 1'b1;
        req_ch.left_primary_weight     <= p.lw[0];
        req_ch.left_secondary_weight   <= p.lw[1];
        req_ch.left_tertiary_weight    <= p.lw[2];
        req_ch.left_quaternary_weight  <= p.lw[3];
        req_ch.right_primary_weight    <= p.rw[0];
        req_ch.right_secondary_weight  <= p.rw[1];
        req_ch.right_tertiary_weight   <= p.rw[2];
        req_ch.right_quaternary_weight <= p.rw[3];
        req_ch.last_element            <= p.last;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        order_board.note_request(p);
        requests_sent++;
    endtask

    // Stops offering until every owed result has come back.
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (order_board.pending() != 0);
    endtask

    // One comparison of n element pairs. Except in noise runs, both sides draw
    // their nonzero weights from a shared list per level, so they line up unless
    // zeros are skewed, a divergent weight is slipped in, or one side goes silent.
    task automatic run_comparison(input int n, input seq_kind_e kind);
        weight_t    pool [LEVELS][32];
        int         li [LEVELS];
        int         ri [LEVELS];
        int         emit_pct [LEVELS];
        int         quiet_lvl;
        bit         quiet_left;
        int         div_lvl;
        int         div_at;
        bit         broken;
        elem_pair_t p;
        for (int lvl = 0; lvl < LEVELS; lvl++)
        begin
            for (int k = 0; k < 32; k++)
            begin
                pool[lvl][k] = pick_weight();
            end
            li[lvl]       = 0;
            ri[lvl]       = 0;
            emit_pct[lvl] = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(60, 100);
        end
        quiet_lvl  = $urandom_range(1, 3);
        quiet_left = ($urandom_range(0, 1) != 0);
        div_lvl    = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 3);
        div_at     = $urandom_range(0, n - 1);
        broken     = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++)
        begin
            for (int lvl = 0; lvl < LEVELS; lvl++)
            begin
                if (kind == SEQ_NOISE)
                begin
                    p.lw[lvl] = ($urandom_range(0, 1) != 0)
                                ? weight_t'($urandom_range(0, 65535)) : weight_t'(0);
                    p.rw[lvl] = ($urandom_range(0, 1) != 0)
                                ? weight_t'($urandom_range(0, 65535)) : weight_t'(0);
                end
                else if (kind == SEQ_OVERFLOW && lvl == quiet_lvl)
                begin
                    p.lw[lvl] = quiet_left ? weight_t'(0) : pool[lvl][li[lvl] % 32];
                    p.rw[lvl] = quiet_left ? pool[lvl][ri[lvl] % 32] : weight_t'(0);
                    li[lvl]++;
                    ri[lvl]++;
                end
                else
                begin
                    p.lw[lvl] = '0;
                    p.rw[lvl] = '0;
                    if ($urandom_range(0, 99) < emit_pct[lvl])
                    begin
                        p.lw[lvl] = pool[lvl][li[lvl] % 32];
                        li[lvl]++;
                    end
                    if ($urandom_range(0, 99) < emit_pct[lvl])
                    begin
                        p.rw[lvl] = pool[lvl][ri[lvl] % 32];
                        ri[lvl]++;
                    end
                    if (kind == SEQ_DIVERGE && i == div_at && lvl == div_lvl)
                    begin
                        p.lw[lvl] = pick_weight();
                    end
                end
            end
            if (kind == SEQ_NOISE)
            begin
                p.last = ($urandom_range(0, 9) == 0);
            end
            else
            begin
                p.last = (i == n - 1) && !broken;
            end
            send_request(p);
        end
    endtask

    initial
    begin : stimulus
        int        n;
        seq_kind_e kind;
        bit        held;
        bit        paused;
        held        = 1'b0;
        paused      = 1'b0;
        order_board = new();

        rst_n                          = 1'b0;
        req_ch.valid                   = 1'b0;
        req_ch.left_primary_weight     = '0;
        req_ch.left_secondary_weight   = '0;
        req_ch.left_tertiary_weight    = '0;
        req_ch.left_quaternary_weight  = '0;
        req_ch.right_primary_weight    = '0;
        req_ch.right_secondary_weight  = '0;
        req_ch.right_tertiary_weight   = '0;
        req_ch.right_quaternary_weight = '0;
        req_ch.last_element            = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Undecided all-zero request, then an empty comparison ending equal.
        send_request(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_request(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        // Primary decisions end the comparison at once, both ways.
        send_request(make_pair(1, 0, 0, 0, 2, 0, 0, 0, 1'b0));
        send_request(make_pair(16'hFFFF, 0, 0, 0, 1, 0, 0, 0, 1'b0));
        // All levels equal: at full scale undecided, then with small weights at the end.
        send_request(make_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_request(make_pair(5, 5, 5, 5, 5, 5, 5, 5, 1'b1));
        // Secondary, tertiary and quaternary settle the order at the end.
        send_request(make_pair(9, 6, 0, 0, 9, 3, 0, 0, 1'b1));
        send_request(make_pair(9, 3, 2, 0, 9, 3, 7, 0, 1'b1));
        send_request(make_pair(9, 3, 2, 1, 9, 3, 2, 16'hFFFF, 1'b1));
        // A side left empty at the end counts as the lighter one.
        send_request(make_pair(7, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_request(make_pair(0, 0, 0, 0, 0, 4, 0, 0, 1'b1));
        // A settled level ignores the weights that follow.
        send_request(make_pair(3, 1, 0, 0, 3, 2, 0, 0, 1'b0));
        send_request(make_pair(3, 9, 0, 0, 3, 1, 0, 0, 1'b1));
        // One side of the secondary queue runs past its depth.
        for (int i = 0; i < 10; i++)
        begin
            send_request(make_pair(4, 16'h8001, 0, 0, 4, 0, 0, 0, 1'b0));
        end
        send_request(make_pair(4, 0, 0, 0, 4, 0, 0, 0, 1'b1));
        // The overflow flag is gone once the next comparison starts.
        send_request(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        wait_for_results();

        // Random comparisons with changing idling on both sides.
        while (requests_sent < TOTAL_ITEMS)
        begin
            if (!hold_results && $urandom_range(0, 99) < 15)
            begin
                sender_busy = !sender_busy;
            end
            if ($urandom_range(0, 99) < 15)
            begin
                receiver_busy = !receiver_busy;
            end
            if (!held && requests_sent >= 600)
            begin
                held          = 1'b1;
                sender_busy   = 1'b1;
                hold_results  = 1'b1;
            end
            if (!paused && requests_sent >= 1200)
            begin
                paused = 1'b1;
                wait_for_results();
            end
            case ($urandom_range(0, 9))
                0, 1, 2:    kind = SEQ_EQUAL;
                3, 4, 5, 6: kind = SEQ_DIVERGE;
                7:          kind = SEQ_OVERFLOW;
                default:    kind = SEQ_NOISE;
            endcase
            if (kind == SEQ_OVERFLOW)
            begin
                n = $urandom_range(10, 20);
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            end
            run_comparison(n, kind);
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (order_board.errors == 0 && order_board.pending() == 0)
        begin
            $display("collation_weight_compare_unit test passed");
        end
        else
        begin
            $display("collation_weight_compare_unit test failed");
        end
        $finish;
    end

endmodule
